>>> sv/moving_average_temperature_display_assert.svh
// Assertion macros for the moving average temperature display.
`ifndef MOVING_AVERAGE_TEMPERATURE_DISPLAY_ASSERT_SVH
`define MOVING_AVERAGE_TEMPERATURE_DISPLAY_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MATD_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define MATD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define MATD_ASSERT_SAME(label, clk, rst_n, pre, post, msg)
`define MATD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

>>> sv/matd_pkg.sv
package matd_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 16;

    // x * 351 / 553 as one multiply and shift, exact for every 10-bit x
    localparam int                SCALE_SH  = 20;
    localparam logic [SCALE_SH-1:0] SCALE_MUL = 20'd665552;

    // Configuration register indexes
    localparam logic [1:0] CFG_REPORT_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_HOLD_TIME        = 2'd1;
    localparam logic [1:0] CFG_CHANGE_THRESHOLD = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0]    REPORT_PERIOD_RST    = 16'd200;
    localparam logic [CNT_W-1:0]    HOLD_TIME_RST        = 16'd3000;
    localparam logic [SAMPLE_W-1:0] CHANGE_THRESHOLD_RST = 10'd20;

    // Report queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [CNT_W-1:0]    report_period;
        logic [CNT_W-1:0]    hold_time;
        logic [SAMPLE_W-1:0] change_threshold;
    } cfg_t;

    // One report handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] scaled_set;
        logic                show_set;
    } rpt_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic logic [SAMPLE_W-1:0] scale_value(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W+SCALE_SH-1:0] prod;
        prod = (SAMPLE_W+SCALE_SH)'(v) * (SAMPLE_W+SCALE_SH)'(SCALE_MUL);
        return prod[SAMPLE_W+SCALE_SH-1:SCALE_SH];
    endfunction

endpackage

>>> sv/matd_front.sv
module matd_front #(
    parameter int WINDOW = 50
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [matd_pkg::SAMPLE_W-1:0]     adc_sample,
    input  logic [matd_pkg::SAMPLE_W-1:0]     set_point,
    input  matd_pkg::cfg_t                    cfg,
    output logic                              push,
    output matd_pkg::rpt_t                    push_data
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW     = matd_pkg::SAMPLE_W;

    // Sample ring and its per-entry valid bits
    logic [SW-1:0]          ring_mem [WINDOW];
    logic [WINDOW-1:0]      valid_reg;
    logic [SW-1:0]          rd_data_reg;
    logic                   rd_valid_reg;

    logic [SLOT_W-1:0]               slot_reg, slot_next, slot_inc, rd_addr;
    logic [matd_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [matd_pkg::CNT_W-1:0]      period_reg, period_next, period_inc;
    logic [matd_pkg::CNT_W-1:0]      hold_reg, hold_next, hold_inc;
    logic                            flag_reg, flag_next;
    logic [SW-1:0]                   base_reg, base_next, base_eff;
    logic                            loaded_reg;
    logic [SW-1:0]                   old_sample, scaled_set, diff;
    logic                            report;

    // Ring pointer, the read port runs one slot ahead of the write
    assign slot_inc   = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    assign slot_next  = accept ? slot_inc : slot_reg;
    assign rd_addr    = slot_next;
    assign old_sample = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_mem[slot_reg] <= adc_sample;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // Running window sum
    assign sum_next = sum_reg - matd_pkg::SUM_W'(old_sample) + matd_pkg::SUM_W'(adc_sample);

    // Report period counter
    assign period_inc  = period_reg + 1'b1;
    assign report      = (period_inc >= cfg.report_period);
    assign period_next = report ? '0 : period_inc;

    // Hold timer, then set-point change detection
    assign scaled_set = matd_pkg::scale_value(set_point);
    assign hold_inc   = hold_reg + 1'b1;
    assign base_eff   = loaded_reg ? base_reg : scaled_set;
    assign diff       = (scaled_set >= base_eff) ? scaled_set - base_eff
                                                 : base_eff - scaled_set;

    always_comb begin
        hold_next = hold_reg;
        flag_next = flag_reg;
        base_next = base_eff;
        if (flag_reg) begin
            hold_next = hold_inc;
            if (hold_inc >= cfg.hold_time) begin
                hold_next = '0;
                flag_next = 1'b0;
            end
        end
        if (diff > cfg.change_threshold) begin
            base_next = scaled_set;
            flag_next = 1'b1;
            hold_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            slot_reg     <= '0;
            sum_reg      <= '0;
            period_reg   <= '0;
            hold_reg     <= '0;
            flag_reg     <= 1'b0;
            base_reg     <= '0;
            loaded_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            slot_reg     <= slot_next;
            if (accept) begin
                valid_reg[slot_reg] <= 1'b1;
                sum_reg    <= sum_next;
                period_reg <= period_next;
                hold_reg   <= hold_next;
                flag_reg   <= flag_next;
                base_reg   <= base_next;
                loaded_reg <= 1'b1;
            end
        end
    end

    // Hand the report to the queue
    assign push                 = accept && report;
    assign push_data.sum        = sum_next;
    assign push_data.scaled_set = scaled_set;
    assign push_data.show_set   = flag_next;

endmodule

>>> sv/matd_fifo.sv
module matd_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  matd_pkg::rpt_t        push_data,
    input  logic                  pop,
    output matd_pkg::rpt_t        pop_data,
    output matd_pkg::q_status_t   status
);

    matd_pkg::rpt_t                  entry_reg [matd_pkg::QUEUE_DEPTH];
    logic [matd_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [matd_pkg::QCNT_W-1:0]     count_reg;

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == matd_pkg::QCNT_W'(matd_pkg::QUEUE_DEPTH));

endmodule

>>> sv/matd_back.sv
module matd_back #(
    parameter int WINDOW = 50
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  matd_pkg::q_status_t   q_status,
    input  matd_pkg::rpt_t        q_data,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic                  m_tuser
);

    localparam int SW        = matd_pkg::SAMPLE_W;
    localparam int SUM_W     = matd_pkg::SUM_W;
    // Divide by WINDOW as multiply by a rounded-up reciprocal, exact for 16-bit sums
    localparam int DIV_SH    = SUM_W + ((WINDOW > 1) ? $clog2(WINDOW) : 1);
    localparam longint DIV_MUL = ((longint'(1) << DIV_SH) + WINDOW - 1) / WINDOW;
    localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);
    localparam int PROD_W    = SUM_W + DIV_MUL_W;

    logic                   a_valid_reg;
    logic [SW-1:0]          a_avg_reg, a_set_reg;
    logic                   a_show_reg;
    logic                   out_valid_reg;
    logic [SW-1:0]          out_avg_reg, out_scaled_reg, out_shown_reg;
    logic                   out_show_reg;

    logic                   a_ready, b_ready;
    logic [PROD_W-1:0]      div_prod;
    logic [SW-1:0]          scaled;

    // Stall chain
    assign b_ready = !out_valid_reg || m_tready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = q_status.valid && a_ready;

    // Window average
    assign div_prod = PROD_W'(q_data.sum) * PROD_W'(DIV_MUL);
    // Scaling of the average
    assign scaled   = matd_pkg::scale_value(a_avg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= q_status.valid;
            end
            if (b_ready) begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            a_avg_reg  <= div_prod[DIV_SH +: SW];
            a_set_reg  <= q_data.scaled_set;
            a_show_reg <= q_data.show_set;
        end
        if (b_ready && a_valid_reg) begin
            out_avg_reg    <= a_avg_reg;
            out_scaled_reg <= scaled;
            out_shown_reg  <= a_show_reg ? a_set_reg : scaled;
            out_show_reg   <= a_show_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_shown_reg, out_scaled_reg, out_avg_reg};
    assign m_tuser  = out_show_reg;

endmodule

>>> sv/moving_average_temperature_display.sv
// Throughput: one input beat per cycle unless the report queue is full; a
// four-entry report queue decouples the sample-ring front end from the divide
// and scale pipeline, whose average and output registers feed m_tvalid.
// Reset: synchronous, active low; clears the ring valid bits, sum, counters,
// hold flag, baseline and queue, and loads the register reset values.
`include "moving_average_temperature_display_assert.svh"

module moving_average_temperature_display #(
    parameter int WINDOW = 50
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [9:0] adc_sample, [19:10] set_point
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [9:0] average_raw, [19:10] average_scaled,
                                    // [29:20] shown_value
    output logic         m_tuser,   // [0] showing_set
    // Register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    matd_pkg::cfg_t       cfg_reg;
    matd_pkg::q_status_t  q_status;
    matd_pkg::rpt_t       push_data, pop_data;
    logic                 accept, push, pop;

    // Register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.report_period    <= matd_pkg::REPORT_PERIOD_RST;
            cfg_reg.hold_time        <= matd_pkg::HOLD_TIME_RST;
            cfg_reg.change_threshold <= matd_pkg::CHANGE_THRESHOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                matd_pkg::CFG_REPORT_PERIOD: begin
                    cfg_reg.report_period <= cfg_data;
                end
                matd_pkg::CFG_HOLD_TIME: begin
                    cfg_reg.hold_time <= cfg_data;
                end
                matd_pkg::CFG_CHANGE_THRESHOLD: begin
                    cfg_reg.change_threshold <= cfg_data[matd_pkg::SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input beats are taken whenever the queue can hold a report
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    matd_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .adc_sample (s_tdata[9:0]),
        .set_point  (s_tdata[19:10]),
        .cfg        (cfg_reg),
        .push       (push),
        .push_data  (push_data)
    );

    matd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    matd_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks
    `MATD_ASSERT_SAME(a_no_overflow, aclk, aresetn, push, !q_status.full, "report queue overflow")
    `MATD_ASSERT_NEXT(a_period_write, aclk, aresetn, cfg_valid && cfg_ready && cfg_index == matd_pkg::CFG_REPORT_PERIOD, cfg_reg.report_period == $past(cfg_data), "period write lost")
    `MATD_ASSERT_SAME(a_shown_meas, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[29:20] == m_tdata[19:10], "shown value not the scaled average")

endmodule

>>> test/matd_checker.sv
// Watches the sample, result and register channels of the display block.
// It keeps its own copy of the window, counters and set-point tracking,
// predicts each report and compares it with the result beats as they leave.
module matd_checker #(
    parameter int WINDOW = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [9:0] adc_sample, [19:10] set_point
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [9:0] average_raw, [19:10] average_scaled,
                                    // [29:20] shown_value
    input  logic        m_tuser,    // [0] showing_set
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          err_count,
    output int          outstanding
);

    typedef struct packed {
        logic [9:0] average_raw;
        logic [9:0] average_scaled;
        logic [9:0] shown_value;
        logic       showing_set;
    } report_t;

    // register copies
    logic [15:0] period_limit;
    logic [15:0] hold_limit;
    logic [9:0]  change_limit;

    // window and tracking state
    logic [9:0]  ring [WINDOW];
    int          slot;
    logic [15:0] window_total;
    logic [15:0] period_cnt;
    logic [15:0] hold_cnt;
    logic        showing;
    logic [9:0]  baseline;
    logic        baseline_valid;

    report_t     pending_reports[$];
    int          errors = 0;

    // converter units to display units, truncated
    function automatic logic [9:0] to_display_units(input logic [9:0] v);
        return 10'((32'(v) * 32'd351) / 32'd553);
    endfunction

    task automatic clear_model();
        period_limit   = 16'd200;
        hold_limit     = 16'd3000;
        change_limit   = 10'd20;
        for (int i = 0; i < WINDOW; i++) ring[i] = '0;
        slot           = 0;
        window_total   = '0;
        period_cnt     = '0;
        hold_cnt       = '0;
        showing        = 1'b0;
        baseline       = '0;
        baseline_valid = 1'b0;
        pending_reports.delete();
    endtask

    task automatic load_register(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            matd_pkg::CFG_REPORT_PERIOD:    period_limit = val;
            matd_pkg::CFG_HOLD_TIME:        hold_limit   = val;
            matd_pkg::CFG_CHANGE_THRESHOLD: change_limit = val[9:0];
            default: ;
        endcase
    endtask

    // one tick: window, period, hold timer, change detect, then maybe a report
    task automatic advance_tick(input logic [9:0] smp, input logic [9:0] sp);
        logic [9:0] sp_scaled;
        logic [9:0] sp_delta;
        logic [9:0] avg;
        logic       due;
        report_t    rep;
        sp_scaled    = to_display_units(sp);
        window_total = window_total - 16'(ring[slot]) + 16'(smp);
        ring[slot]   = smp;
        slot         = (slot == WINDOW - 1) ? 0 : slot + 1;

        period_cnt = period_cnt + 16'd1;
        due        = (period_cnt >= period_limit);
        if (due) period_cnt = '0;

        if (showing) begin
            hold_cnt = hold_cnt + 16'd1;
            if (hold_cnt >= hold_limit) begin
                hold_cnt = '0;
                showing  = 1'b0;
            end
        end

        // first tick takes the set-point as its baseline
        if (!baseline_valid) begin
            baseline       = sp_scaled;
            baseline_valid = 1'b1;
        end
        sp_delta = (sp_scaled >= baseline) ? sp_scaled - baseline : baseline - sp_scaled;
        if (sp_delta > change_limit) begin
            baseline = sp_scaled;
            showing  = 1'b1;
            hold_cnt = '0;
        end

        if (due) begin
            avg                = 10'(window_total / 16'(WINDOW));
            rep.average_raw    = avg;
            rep.average_scaled = to_display_units(avg);
            rep.shown_value    = showing ? sp_scaled : rep.average_scaled;
            rep.showing_set    = showing;
            pending_reports.push_back(rep);
        end
    endtask

    task automatic check_report(input logic [31:0] d, input logic u);
        report_t want;
        if (pending_reports.size() == 0) begin
            errors++;
            $error("result beat with no report pending: tdata %h tuser %b", d, u);
            return;
        end
        want = pending_reports.pop_front();
        if (d[9:0] !== want.average_raw) begin
            errors++;
            $error("average_raw: expected %0d, got %0d", want.average_raw, d[9:0]);
        end
        if (d[19:10] !== want.average_scaled) begin
            errors++;
            $error("average_scaled: expected %0d, got %0d", want.average_scaled, d[19:10]);
        end
        if (d[29:20] !== want.shown_value) begin
            errors++;
            $error("shown_value: expected %0d, got %0d", want.shown_value, d[29:20]);
        end
        if (u !== want.showing_set) begin
            errors++;
            $error("showing_set: expected %0d, got %0d", want.showing_set, u);
        end
    endtask

    // results leave before this edge's sample can produce one, so check them first
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata, m_tuser);
            if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) advance_tick(s_tdata[9:0], s_tdata[19:10]);
        end
        outstanding <= pending_reports.size();
        err_count   <= errors;
    end

endmodule

>>> test/tb_top.sv
module tb_top;

    localparam int SETTLE      = 8;     // covers the queue and the average and output registers
    localparam int STALL_LIMIT = 2000;  // cycles without any beat before giving up

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = matd_pkg::CFG_REPORT_PERIOD;
    logic [15:0] cfg_data  = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_ready;
    int          err_count;
    int          outstanding;

    logic        quiet     = 1'b0;  // no idling on either side
    logic        gaps_on   = 1'b1;
    logic [9:0]  last_sample = '0;
    logic [9:0]  last_setp   = '0;
    int          ready_run = 0;
    int          stall_run = 0;
    int          idle_cycles = 0;

    always #10 aclk = ~aclk;

    moving_average_temperature_display u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    matd_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .err_count   (err_count),
        .outstanding (outstanding)
    );

    // result side back-pressure: random stall bursts between ready runs
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            m_tready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            m_tready <= 1'b1;
        end else begin
            stall_run = $urandom_range(0, 5);
            ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                    : $urandom_range(1, 12);
            m_tready <= 1'b0;
        end
    end

    // watchdog: any beat on any channel counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one tick beat, with an optional sender gap in front of it
    task automatic send_tick(input logic [9:0] smp, input logic [9:0] sp);
        if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, sp, smp};
        do @(posedge aclk); while (!s_tready);
    endtask

    // samples: extremes, slow drift or anything; set-point: mostly held, with
    // small steps around the threshold and occasional jumps
    task automatic pick_tick(output logic [9:0] smp, output logic [9:0] sp);
        int v;
        int w;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 1023;
            2, 3:    v = int'(last_sample) + int'($urandom_range(0, 16)) - 8;
            default: v = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w = int'(last_setp);
            5, 6:          w = int'(last_setp) + int'($urandom_range(0, 80)) - 40;
            7:             w = ($urandom_range(0, 1) == 1) ? 1023 : 0;
            default:       w = $urandom_range(0, 1023);
        endcase
        v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
        w = (w < 0) ? 0 : (w > 1023) ? 1023 : w;
        smp         = 10'(v);
        sp          = 10'(w);
        last_sample = smp;
        last_setp   = sp;
    endtask

    task automatic run_random(input int n);
        logic [9:0] smp;
        logic [9:0] sp;
        for (int i = 0; i < n; i++) begin
            if (i % 20 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            pick_tick(smp, sp);
            send_tick(smp, sp);
        end
        s_tvalid <= 1'b0;
    endtask

    // wait for every predicted report, then let any report-less tick clear the pipe
    task automatic wait_for_reports();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] period, input logic [15:0] hold,
                              input logic [15:0] thresh);
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    cfg_index <= matd_pkg::CFG_REPORT_PERIOD;
                    cfg_data  <= period;
                end
                1: begin
                    cfg_index <= matd_pkg::CFG_HOLD_TIME;
                    cfg_data  <= hold;
                end
                default: begin
                    cfg_index <= matd_pkg::CFG_CHANGE_THRESHOLD;
                    cfg_data  <= thresh;
                end
            endcase
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed ticks under reset settings: first-tick baseline, full-scale
        // jumps, a change while showing, and steps either side of the threshold
        send_tick(10'd1023, 10'd512);
        send_tick(10'd0,    10'd512);
        send_tick(10'd1023, 10'd1023);
        send_tick(10'd0,    10'd0);
        send_tick(10'd512,  10'd33);
        send_tick(10'd511,  10'd34);
        send_tick(10'd1023, 10'd34);
        send_tick(10'd0,    10'd34);
        send_tick(10'h155,  10'h2AA);
        send_tick(10'h2AA,  10'h155);
        send_tick(10'd1,    10'd1);
        send_tick(10'd1022, 10'd1022);
        last_setp = 10'd1022;
        // carry on past the reset report period
        run_random(193);
        wait_for_reports();

        // report every tick, any set-point change shows
        set_config(16'd1, 16'd1, 16'd0);
        run_random(40);
        wait_for_reports();

        // zero period and zero hold
        set_config(16'd0, 16'd0, 16'd5);
        run_random(30);
        wait_for_reports();

        // longest period and hold: counters climb with no reports
        set_config(16'hFFFF, 16'hFFFF, 16'd0);
        run_random(25);
        wait_for_reports();

        // lowered period and hold end on the next tick; no change can pass
        set_config(16'd2, 16'd3, 16'd1023);
        run_random(40);
        wait_for_reports();

        set_config(16'd7, 16'd20, 16'd10);
        run_random(100);
        wait_for_reports();

        // closing stretch at full rate on both sides
        quiet <= 1'b1;
        set_config(16'd3, 16'd9, 16'd2);
        run_random(80);
        wait_for_reports();

        if (err_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> moving_average_temperature_display.f
+incdir+sv
sv/matd_pkg.sv
sv/matd_front.sv
sv/matd_fifo.sv
sv/matd_back.sv
sv/moving_average_temperature_display.sv
test/matd_checker.sv
test/tb_top.sv
